FILE: hdl/ipid_pkg.sv
// Shared types, widths and constants of the incremental PID controller.
`default_nettype none

package ipid_pkg;

  // Field and datapath widths
  localparam int SAMPLE_BITS    = 10;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS  = 16;
  localparam int GAIN_W         = 20;
  localparam int OUT_W          = 32;
  localparam int ERR_W          = SAMPLE_BITS + 2;
  localparam int D1_W           = ERR_W + 1;
  localparam int D2_W           = ERR_W + 2;
  localparam int PROD_W         = GAIN_W + 1 + D2_W;
  localparam int DELTA_W        = PROD_W + 2;
  localparam int UP_SHIFT       = (OUT_FRAC_BITS > GAIN_FRAC_BITS) ?
                                  (OUT_FRAC_BITS - GAIN_FRAC_BITS) : 0;
  localparam int DN_SHIFT       = (GAIN_FRAC_BITS > OUT_FRAC_BITS) ?
                                  (GAIN_FRAC_BITS - OUT_FRAC_BITS) : 0;
  localparam int SCALE_W        = DELTA_W + UP_SHIFT;
  localparam int SUM_W          = ((SCALE_W > OUT_W) ? SCALE_W : OUT_W) + 1;

  // Stream and config port widths
  localparam int IN_TDATA_W     = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = GAIN_W;

  // Queue between front and back
  localparam int Q_DEPTH        = 4;
  localparam int Q_PTR_W        = $clog2(Q_DEPTH);
  localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

  // Symmetric clamp limit of the accumulator
  localparam logic signed [OUT_W-1:0] ACC_MAX = {1'b0, {(OUT_W-1){1'b1}}};

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] TARGET_RST = '0;
  localparam logic [GAIN_W-1:0]      GAIN_P_RST = GAIN_W'(23593);
  localparam logic [GAIN_W-1:0]      GAIN_I_RST = GAIN_W'(367);
  localparam logic [GAIN_W-1:0]      GAIN_D_RST = GAIN_W'(1769);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_GAIN_P = 2'd1,
    CFG_GAIN_I = 2'd2,
    CFG_GAIN_D = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  // One classified request as it waits in the queue
  typedef struct packed {
    logic                    clear;
    logic                    pass;
    logic signed [ERR_W-1:0] err;
    logic signed [D1_W-1:0]  d1;
    logic signed [D2_W-1:0]  d2;
  } item_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } qstat_t;

endpackage

`default_nettype wire

FILE: hdl/incremental_pid_controller_core.sv
// Path: a request passes the queue, then the product, increment and output registers.
// Throughput: one sample per cycle while m_axis is not stalled; the accumulator add
// and clamp close their loop through the accumulator register in the back end.
// Reset: gains and target go to their defaults, error history and
// accumulator clear to zero, the request queue and pipeline empty.
`default_nettype none

module incremental_pid_controller_core (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Config write port
  input  wire                                 cfg_we_i,
  input  wire [ipid_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire [ipid_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Sample stream
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire [ipid_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // light_sample, edge_side, zero pad
  input  wire [0:0]                           s_axis_tuser,  // mode
  // Drive stream
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [ipid_pkg::OUT_W-1:0]          m_axis_tdata,  // drive_value
  output logic [0:0]                          m_axis_tuser   // saturated
);
  import ipid_pkg::*;

  logic [SAMPLE_BITS-1:0] target_q;
  gains_t                 gains_q;
  qstat_t                 q_stat;
  item_t                  front_item;
  item_t                  back_item;
  logic                   q_push;
  logic                   q_pop;
  logic                   sat;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TARGET_RST;
      gains_q.kp <= GAIN_P_RST;
      gains_q.ki <= GAIN_I_RST;
      gains_q.kd <= GAIN_D_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET: target_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_GAIN_P: gains_q.kp <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_I: gains_q.ki <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_D: gains_q.kd <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  ipid_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tuser[0]),
    .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .edge_i     (s_axis_tdata[SAMPLE_BITS]),
    .target_i   (target_q),
    .qstat_i    (q_stat),
    .push_o     (q_push),
    .item_o     (front_item)
  );

  ipid_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (front_item),
    .pop_i  (q_pop),
    .item_o (back_item),
    .stat_o (q_stat)
  );

  ipid_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (q_stat),
    .item_i      (back_item),
    .gains_i     (gains_q),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .drive_o     (m_axis_tdata),
    .sat_o       (sat)
  );

  assign m_axis_tuser[0] = sat;

  // A clipped result sits exactly at one of the clamp limits
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      ($signed(m_axis_tdata) == ACC_MAX) || ($signed(m_axis_tdata) == -ACC_MAX))
    else $error("saturated result not at clamp limit");

  // Symmetric clamp never lets the most negative code out
  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata != {1'b1, {(OUT_W-1){1'b0}}}))
    else $error("drive value outside symmetric range");

  // Back end only pops a queue that holds something
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // Fill count rises by one on a push without a pop
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push && !q_pop |=> q_stat.count == $past(q_stat.count) + 1'b1)
    else $error("queue count did not follow push");

endmodule

`default_nettype wire

FILE: hdl/ipid_front.sv
// Front end: accepts samples, forms the error and its differences, keeps error history.
`default_nettype none

module ipid_front (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire                               mode_i,
  input  wire [ipid_pkg::SAMPLE_BITS-1:0]   sample_i,
  input  wire                               edge_i,
  input  wire [ipid_pkg::SAMPLE_BITS-1:0]   target_i,
  input  ipid_pkg::qstat_t                  qstat_i,
  output logic                              push_o,
  output ipid_pkg::item_t                   item_o
);
  import ipid_pkg::*;

  logic                    accept;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] e1_q, e1_d;
  logic signed [ERR_W-1:0] e2_q, e2_d;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign push_o     = accept;

  // Error and its first and second differences
  always_comb begin
    err = $signed({2'b00, target_i}) - $signed({2'b00, sample_i});
    item_o.clear = mode_i;
    item_o.pass  = edge_i;
    item_o.err   = err;
    item_o.d1    = D1_W'(err) - D1_W'(e1_q);
    item_o.d2    = D2_W'(err) - (D2_W'(e1_q) <<< 1) + D2_W'(e2_q);
  end

  // History update; a clear request zeroes it
  always_comb begin
    e1_d = e1_q;
    e2_d = e2_q;
    if (accept) begin
      if (mode_i) begin
        e1_d = '0;
        e2_d = '0;
      end else begin
        e1_d = err;
        e2_d = e1_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q <= '0;
      e2_q <= '0;
    end else begin
      e1_q <= e1_d;
      e2_q <= e2_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ipid_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none

module ipid_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  ipid_pkg::item_t      item_i,
  input  wire                  pop_i,
  output ipid_pkg::item_t      item_o,
  output ipid_pkg::qstat_t     stat_o
);
  import ipid_pkg::*;

  item_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = rd_ptr_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

`default_nettype wire

FILE: hdl/ipid_back.sv
// Back end: gain products, increment sum, saturating accumulate and output register.
`default_nettype none

module ipid_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  ipid_pkg::qstat_t             qstat_i,
  input  ipid_pkg::item_t              item_i,
  input  ipid_pkg::gains_t             gains_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [ipid_pkg::OUT_W-1:0]   drive_o,
  output logic                         sat_o
);
  import ipid_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(ACC_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(ACC_MAX);

  logic adv;

  // Stage 1: products
  logic                     v1_q;
  logic                     clr1_q, pass1_q;
  logic signed [PROD_W-1:0] pp_q, pi_q, pd_q;
  logic signed [PROD_W-1:0] pp_d, pi_d, pd_d;

  // Stage 2: increment
  logic                      v2_q;
  logic                      clr2_q, pass2_q;
  logic signed [DELTA_W-1:0] delta_q, delta_d;

  // Stage 3: accumulator and output register
  logic                      acc_en;
  logic signed [OUT_W-1:0]   acc_q, acc_d;
  logic signed [SCALE_W-1:0] scaled;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   clamped;
  logic                      sat_d;
  logic signed [OUT_W-1:0]   drive_d;
  logic                      out_valid_q;
  logic [OUT_W-1:0]          drive_q;
  logic                      sat_q;

  // Whole pipe moves when the output register is free or drained
  assign adv         = !out_valid_q || out_ready_i;
  assign pop_o       = adv && !qstat_i.empty;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign sat_o       = sat_q;

  // Gain products
  always_comb begin
    pp_d = $signed({1'b0, gains_i.kp}) * item_i.d1;
    pi_d = $signed({1'b0, gains_i.ki}) * item_i.err;
    pd_d = $signed({1'b0, gains_i.kd}) * item_i.d2;
  end

  // Increment in gain fraction bits
  assign delta_d = DELTA_W'(pp_q) + DELTA_W'(pi_q) + DELTA_W'(pd_q);

  // Rescale, accumulate and clamp
  always_comb begin
    scaled  = (SCALE_W'(delta_q) <<< UP_SHIFT) >>> DN_SHIFT;
    sum     = SUM_W'(acc_q) + SUM_W'(scaled);
    clamped = sum;
    sat_d   = 1'b0;
    if (sum > SUM_MAX) begin
      clamped = SUM_MAX;
      sat_d   = 1'b1;
    end else if (sum < SUM_MIN) begin
      clamped = SUM_MIN;
      sat_d   = 1'b1;
    end
    if (clr2_q) begin
      acc_d = '0;
      sat_d = 1'b0;
    end else begin
      acc_d = OUT_W'(clamped);
    end
    drive_d = pass2_q ? acc_d : -acc_d;
    acc_en  = adv && v2_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (adv) begin
        v1_q        <= pop_o;
        v2_q        <= v1_q;
        out_valid_q <= v2_q;
      end
      if (acc_en) acc_q <= acc_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q    <= pp_d;
      pi_q    <= pi_d;
      pd_q    <= pd_d;
      clr1_q  <= item_i.clear;
      pass1_q <= item_i.pass;
      delta_q <= delta_d;
      clr2_q  <= clr1_q;
      pass2_q <= pass1_q;
    end
    if (acc_en) begin
      drive_q <= drive_d;
      sat_q   <= sat_d;
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking stream testbench for the incremental PID controller core.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipid_pkg::*;

  localparam int     STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int     HOLD_AT     = 150;   // result count that starts the long back-pressure
  localparam int     HOLD_LEN    = 120;
  localparam int     TAIL_CYCLES = 8;     // longer than the pipeline latency
  localparam longint ACC_LIM     = longint'(ACC_MAX);
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  // One sample request as the sender offers it
  typedef struct packed {
    logic                   mode;
    logic [SAMPLE_BITS-1:0] level;
    logic                   pass;
  } sample_t;

  // One predicted drive result
  typedef struct packed {
    logic signed [OUT_W-1:0] drive;
    logic                    sat;
  } drive_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;  // light_sample, edge_side, zero pad
  logic [0:0]            s_axis_tuser  = '0;  // mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;        // drive_value
  logic [0:0]            m_axis_tuser;        // saturated

  incremental_pid_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial forever #10 clk_i = ~clk_i;

  // Controller copy: registers and history
  logic [SAMPLE_BITS-1:0] set_point = TARGET_RST;
  logic [GAIN_W-1:0]      kp = GAIN_P_RST;
  logic [GAIN_W-1:0]      ki = GAIN_I_RST;
  logic [GAIN_W-1:0]      kd = GAIN_D_RST;
  longint                 err_z1 = 0;
  longint                 err_z2 = 0;
  longint                 mv_acc = 0;

  sample_t sample_q[$];
  drive_t  expected_drive_q[$];

  int n_issued  = 0;
  int n_results = 0;
  int n_errors  = 0;
  int idle_cycles = 0;

  // One controller step: clear, or velocity-form update, clamp, edge sign
  function automatic drive_t pid_update(sample_t s);
    longint e;
    longint incr;
    longint total;
    drive_t r;
    r.sat   = 1'b0;
    r.drive = '0;
    if (s.mode) begin
      err_z1 = 0;
      err_z2 = 0;
      mv_acc = 0;
      return r;
    end
    e = longint'(set_point) - longint'(s.level);
    incr = longint'(kp) * (e - err_z1) + longint'(ki) * e
         + longint'(kd) * (e - 2 * err_z1 + err_z2);
    // rescale to the output fraction; narrowing floors
    if (DN_SHIFT > 0) incr = incr >>> DN_SHIFT;
    else incr = incr <<< UP_SHIFT;
    total = mv_acc + incr;
    if (total > ACC_LIM) begin
      total = ACC_LIM;
      r.sat = 1'b1;
    end else if (total < -ACC_LIM) begin
      total = -ACC_LIM;
      r.sat = 1'b1;
    end
    err_z2  = err_z1;
    err_z1  = e;
    mv_acc  = total;
    r.drive = OUT_W'(s.pass ? total : -total);
    return r;
  endfunction

  // Per-request wait, with occasional runs of back-to-back traffic
  function automatic int draw_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s at result %0d: got %0d, expected %0d",
             $realtime, what, n_results, got, want);
    n_errors++;
  endtask

  // Driver: offers queued samples with random gaps between requests
  int      tx_gap = 0;
  int      tx_run = 0;
  sample_t tx_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      tx_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        tx_next = sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({tx_next.pass, tx_next.level});
        s_axis_tuser  <= tx_next.mode;
        tx_gap = draw_wait(tx_run);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on accepted requests, checks results, drives tready
  int      rx_gap = 0;
  int      rx_run = 0;
  int      hold_left = 0;
  sample_t rx_seen;
  drive_t  rx_want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap    = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_drive_q.size() == 0) begin
          report_mismatch("unexpected result", longint'($signed(m_axis_tdata)), 0);
        end else begin
          rx_want = expected_drive_q.pop_front();
          if (m_axis_tdata !== rx_want.drive)
            report_mismatch("drive_value", longint'($signed(m_axis_tdata)),
                            longint'(rx_want.drive));
          if (m_axis_tuser[0] !== rx_want.sat)
            report_mismatch("saturated", longint'(m_axis_tuser[0]), longint'(rx_want.sat));
        end
        // one long stall so the pipeline backs up into the input
        if (n_results == HOLD_AT) hold_left = HOLD_LEN;
        else rx_gap = draw_wait(rx_run);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rx_seen.mode  = s_axis_tuser[0];
        rx_seen.level = s_axis_tdata[SAMPLE_BITS-1:0];
        rx_seen.pass  = s_axis_tdata[SAMPLE_BITS];
        expected_drive_q.push_back(pid_update(rx_seen));
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: no handshake anywhere for too long ends the run
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_sample(input logic mode, input int level, input logic pass);
    sample_t s;
    s.mode  = mode;
    s.level = SAMPLE_BITS'(level);
    s.pass  = pass;
    sample_q.push_back(s);
    n_issued++;
  endtask

  // Register write; the local copy keeps only the register's width
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_TARGET: set_point = val[SAMPLE_BITS-1:0];
      CFG_GAIN_P: kp = val[GAIN_W-1:0];
      CFG_GAIN_I: ki = val[GAIN_W-1:0];
      CFG_GAIN_D: kd = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every request has produced its result, then let the pipe settle
  task automatic wait_drained();
    do @(posedge clk_i); while (n_results < n_issued);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return GAIN_MAX;
      2: return GAIN_W'($urandom_range(0, 4095));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  // Random sample: mostly control steps, levels biased to extremes and the set point
  task automatic push_random_sample();
    int level;
    case ($urandom_range(0, 7))
      0: level = 0;
      1: level = (1 << SAMPLE_BITS) - 1;
      2: level = int'(set_point) + $urandom_range(0, 8) - 4;
      default: level = $urandom_range(0, (1 << SAMPLE_BITS) - 1);
    endcase
    push_sample($urandom_range(0, 24) == 0, level, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults: clear, field extremes, alternating bit patterns
    push_sample(1'b1, 0, 1'b0);
    push_sample(1'b0, 0, 1'b1);
    push_sample(1'b0, 1023, 1'b0);
    push_sample(1'b0, 1023, 1'b1);
    push_sample(1'b0, 0, 1'b0);
    push_sample(1'b0, 'h2AA, 1'b1);
    push_sample(1'b0, 'h155, 1'b0);
    push_sample(1'b1, 1023, 1'b1);  // clear ignores level and edge side
    push_sample(1'b0, 512, 1'b1);
    wait_drained();

    // Full-scale gains, top set point: positive clipping, then the swing back.
    // Upper data bits on the target write must be dropped.
    write_reg(CFG_TARGET, '1);
    write_reg(CFG_GAIN_P, GAIN_MAX);
    write_reg(CFG_GAIN_I, GAIN_MAX);
    write_reg(CFG_GAIN_D, GAIN_MAX);
    push_sample(1'b0, 0, 1'b1);
    push_sample(1'b0, 0, 1'b1);
    push_sample(1'b0, 0, 1'b0);
    push_sample(1'b0, 1023, 1'b1);
    push_sample(1'b0, 1023, 1'b0);
    push_sample(1'b1, 0, 1'b0);
    wait_drained();

    // Zero set point: negative clipping
    write_reg(CFG_TARGET, CFG_DATA_W'('hFFC00));
    push_sample(1'b0, 1023, 1'b1);
    push_sample(1'b0, 1023, 1'b1);
    push_sample(1'b0, 1023, 1'b0);
    push_sample(1'b0, 0, 1'b1);
    wait_drained();

    // All gains zero: the accumulator holds
    write_reg(CFG_GAIN_P, '0);
    write_reg(CFG_GAIN_I, '0);
    write_reg(CFG_GAIN_D, '0);
    write_reg(CFG_TARGET, CFG_DATA_W'(512));
    push_sample(1'b0, 0, 1'b1);
    push_sample(1'b0, 1023, 1'b0);
    push_sample(1'b0, 512, 1'b1);
    wait_drained();

    // Random phases, each with freshly drawn registers
    for (int phase = 0; phase < 7; phase++) begin
      write_reg(CFG_TARGET, CFG_DATA_W'($urandom));
      write_reg(CFG_GAIN_P, pick_gain());
      write_reg(CFG_GAIN_I, pick_gain());
      write_reg(CFG_GAIN_D, pick_gain());
      for (int k = 0; k < 100; k++) push_random_sample();
      wait_drained();
    end

    if (expected_drive_q.size() != 0)
      report_mismatch("results still outstanding", 0, longint'(expected_drive_q.size()));
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
